FILE: rtl/core/descending_sort_engine_top_macros.svh
// Assertion helpers, clocked on i_clk, disabled while i_rst_n is low.
`ifndef DESCENDING_SORT_ENGINE_TOP_MACROS_SVH
`define DESCENDING_SORT_ENGINE_TOP_MACROS_SVH

// Same-cycle implication.
`define DSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dse_pkg.sv
`default_nettype none
package dse_pkg;

    localparam int DATA_W = 32;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctrl;

endpackage
`default_nettype wire

FILE: rtl/core/dse_cell.sv
`default_nettype none
module dse_cell
    import dse_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire signed [DATA_W-1:0]  i_new_value,
    input  wire signed [DATA_W-1:0]  i_left_value,
    input  wire                      i_left_valid,
    input  wire                      i_left_gt,
    input  wire signed [DATA_W-1:0]  i_right_value,
    input  wire                      i_right_valid,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_valid,
    output logic                     o_gt
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     r_valid;
    logic                     n_valid;

    // empty cell ranks below any value
    assign o_gt    = !r_valid || (i_new_value > r_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.pop) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctrl.insert) begin
            if (i_left_gt && i_left_valid) begin
                // left neighbor evicts its value to us
                n_value = i_left_value;
                n_valid = 1'b1;
            end else if (o_gt && !i_left_gt) begin
                n_value = i_new_value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
`default_nettype wire

FILE: rtl/core/descending_sort_engine_top.sv
// Loading: one item per cycle, inserted into the sorted cell chain in the cycle it is taken;
// an item taken while the chain is full is dropped and sets the overflow flag. The first
// result is offered in the cycle after the item marked last is accepted. Emitting: one
// result per cycle while i_ready is high, one per stored value; input is held off meanwhile.
// Synchronous active-low reset empties the chain and clears the overflow flag.
`default_nettype none
`include "descending_sort_engine_top_macros.svh"
module descending_sort_engine_top
    import dse_pkg::*;
#(
    parameter int MAX_ITEMS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire signed [DATA_W-1:0]  i_value,
    input  wire                      i_last,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_last_out,
    output logic                     o_overflow
);

    logic                     r_state;
    logic                     n_state;
    logic                     r_overflow;
    logic                     n_overflow;
    logic                     w_in_acc;
    logic                     w_out_acc;
    logic                     w_set_done;
    logic                     w_full;
    t_cell_ctrl               w_ctrl;
    logic signed [DATA_W-1:0] w_value [MAX_ITEMS];
    logic                     w_valid [MAX_ITEMS];
    logic                     w_gt    [MAX_ITEMS];

    assign o_ready    = (r_state == ST_LOAD);
    assign o_valid    = (r_state == ST_EMIT);
    assign w_in_acc   = i_valid && o_ready;
    assign w_out_acc  = o_valid && i_ready;
    assign w_set_done = w_out_acc && o_last_out;
    assign w_full     = w_valid[MAX_ITEMS-1];

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.pop    = w_out_acc;

    assign o_sorted_value = w_value[0];
    assign o_last_out     = w_valid[0] && !w_valid[1];
    assign o_overflow     = r_overflow;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            logic signed [DATA_W-1:0] w_l_value;
            logic                     w_l_valid;
            logic                     w_l_gt;
            logic signed [DATA_W-1:0] w_r_value;
            logic                     w_r_valid;

            if (gi == 0) begin : g_head
                assign w_l_value = '0;
                assign w_l_valid = 1'b0;
                assign w_l_gt    = 1'b0;
            end else begin : g_body
                assign w_l_value = w_value[gi-1];
                assign w_l_valid = w_valid[gi-1];
                assign w_l_gt    = w_gt[gi-1];
            end

            if (gi == MAX_ITEMS - 1) begin : g_tail
                assign w_r_value = '0;
                assign w_r_valid = 1'b0;
            end else begin : g_inner
                assign w_r_value = w_value[gi+1];
                assign w_r_valid = w_valid[gi+1];
            end

            dse_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_new_value   (i_value),
                .i_left_value  (w_l_value),
                .i_left_valid  (w_l_valid),
                .i_left_gt     (w_l_gt),
                .i_right_value (w_r_value),
                .i_right_valid (w_r_valid),
                .o_value       (w_value[gi]),
                .o_valid       (w_valid[gi]),
                .o_gt          (w_gt[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_overflow = r_overflow;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_overflow = 1'b1;
                    end
                    if (i_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_set_done) begin
                    n_state    = ST_LOAD;
                    n_overflow = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

    `DSE_ASSERT_NOW(a_emit_has_data, o_valid, w_valid[0], "emitting from an empty chain")
    `DSE_ASSERT_NEXT(a_load_after_set, w_set_done, o_ready && !w_valid[0], "set not cleared")
    `DSE_ASSERT_NOW(a_ovf_only_full, r_overflow && o_ready, w_full, "overflow with free cells")
    `DSE_ASSERT_NOW(a_chain_packed, w_valid[1], w_valid[0], "hole at head of chain")

endmodule
`default_nettype wire
